// ----- src/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // Update control broadcast from the top level to every cell.
    typedef struct packed {
        logic upd;    // apply the update of the current word this cycle
        logic set;    // current word is a set
        logic hit;    // some cell matched the key
        logic evict;  // a new key must replace the least recent entry
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/lkvc_cell.sv -----
// One storage cell of the cache: valid mark, key, value, recency rank and match flag.
`default_nettype none

module lkvc_cell #(
    parameter int RW = 4
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          lookup,
    input  wire [lkvc_pkg::DATA_W-1:0]   look_key,
    input  wire lkvc_pkg::cell_ctl_t     ctl,
    input  wire [RW-1:0]                 hit_rank,
    input  wire [RW-1:0]                 old_rank,
    input  wire                          ins_here,
    input  wire [lkvc_pkg::DATA_W-1:0]   wr_key,
    input  wire [lkvc_pkg::DATA_W-1:0]   wr_value,
    output logic                         match,
    output logic [RW-1:0]                rank,
    output logic [lkvc_pkg::DATA_W-1:0]  data
);

    logic                        valid_reg, valid_next;
    logic                        match_reg, match_next;
    logic [RW-1:0]               rank_reg, rank_next;
    logic [lkvc_pkg::DATA_W-1:0] key_reg, key_next;
    logic [lkvc_pkg::DATA_W-1:0] value_reg, value_next;
    logic                        evicting;
    logic                        take;

    always_comb
    begin
        valid_next = valid_reg;
        match_next = match_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        evicting   = ctl.evict && valid_reg && (rank_reg == old_rank);
        take       = evicting || (!ctl.evict && ins_here);

        if (lookup)
        begin
            match_next = valid_reg && (key_reg == look_key);
        end

        if (ctl.upd)
        begin
            if (ctl.hit)
            begin
                // Touch: the matched entry becomes most recent, newer ones age by one.
                if (match_reg)
                begin
                    rank_next = '0;
                    if (ctl.set)
                    begin
                        value_next = wr_value;
                    end
                end
                else if (valid_reg && (rank_reg < hit_rank))
                begin
                    rank_next = rank_reg + RW'(1);
                end
            end
            else if (ctl.set)
            begin
                // Insert: the evicted or next free cell takes the new key, all others age.
                if (take)
                begin
                    valid_next = 1'b1;
                    key_next   = wr_key;
                    value_next = wr_value;
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg  <= rank_next;
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign match = match_reg;
    assign rank  = rank_reg;
    assign data  = value_reg;

endmodule

`default_nettype wire

// ----- src/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key-value cache.
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement, built as a row
// of MAX_ENTRIES cells. In the cycle a word is accepted every cell compares the key in
// parallel and registers its match flag; in the S_UPD state that follows, the matched rank
// and value are gathered and every cell applies its recency update (touch or insert with
// eviction). A new word is accepted only once S_UPD is left, so the cache holds one word at
// a time; a get whose result register is still full waits in S_UPD until out_ready takes
// the earlier result. Valid marks clear at reset, so the block is ready straight out of
// reset. The capacity register (cfg_data, reset 16, zero acts as 1, values above
// MAX_ENTRIES act as MAX_ENTRIES) may be written only while the cache is idle.

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [lkvc_pkg::CAP_W-1:0]           cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 command,
    input  wire signed [lkvc_pkg::DATA_W-1:0]   key,
    input  wire signed [lkvc_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]  read_value
);

    localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } state_t;

    state_t                      state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        hit_reg, hit_next;
    logic [lkvc_pkg::DATA_W-1:0] read_value_reg, read_value_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [lkvc_pkg::CAP_W-1:0]  cap_reg;
    logic                        cmd_reg;
    logic [lkvc_pkg::DATA_W-1:0] key_reg;
    logic [lkvc_pkg::DATA_W-1:0] value_reg;

    logic                        accept;
    logic                        go;
    logic                        hit_any;
    logic [RW-1:0]               hit_rank;
    logic [lkvc_pkg::DATA_W-1:0] hit_value;
    logic [RW-1:0]               old_full;
    logic [CMPW-1:0]             cap_ext;
    logic [CMPW-1:0]             eff_cap;
    logic                        evict;
    lkvc_pkg::cell_ctl_t         ctl;

    logic [MAX_ENTRIES-1:0]                   cell_match;
    logic [RW-1:0]                            cell_rank [MAX_ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0]              cell_data [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]                   ins_here;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign go        = (state_reg == S_UPD)
                       && ((cmd_reg == lkvc_pkg::CMD_SET) || !out_valid_reg || out_ready);

    // Gather the matched entry; at most one cell matches.
    always_comb
    begin
        hit_any   = 1'b0;
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_any   = hit_any | cell_match[i];
            hit_rank  = hit_rank | (cell_rank[i] & {RW{cell_match[i]}});
            hit_value = hit_value | (cell_data[i] & {lkvc_pkg::DATA_W{cell_match[i]}});
        end
    end

    always_comb
    begin
        cap_ext  = CMPW'(cap_reg);
        old_full = RW'(count_reg - CW'(1));
        if (cap_reg == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > CMPW'(MAX_ENTRIES))
        begin
            eff_cap = CMPW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        evict = (CMPW'(count_reg) >= eff_cap);
    end

    always_comb
    begin
        ctl.upd   = go;
        ctl.set   = (cmd_reg == lkvc_pkg::CMD_SET);
        ctl.hit   = hit_any;
        ctl.evict = evict;
    end

    // Valid entries always occupy the lowest slots, so the next free one is at count.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        assign ins_here[i] = (count_reg == CW'(i));

        lkvc_cell #(
            .RW (RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .lookup   (accept),
            .look_key (key),
            .ctl      (ctl),
            .hit_rank (hit_rank),
            .old_rank (old_full),
            .ins_here (ins_here[i]),
            .wr_key   (key_reg),
            .wr_value (value_reg),
            .match    (cell_match[i]),
            .rank     (cell_rank[i]),
            .data     (cell_data[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        read_value_next = read_value_reg;
        count_next      = count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                    if (cmd_reg == lkvc_pkg::CMD_GET)
                    begin
                        out_valid_next  = 1'b1;
                        hit_next        = hit_any;
                        read_value_next = hit_any ? hit_value : lkvc_pkg::MISS_VALUE;
                    end
                    else if (!hit_any && !evict)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            read_value_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            hit_reg        <= hit_next;
            read_value_reg <= read_value_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire

// ----- src/lkvc_checker.sv -----
// Port-level checker for the LRU key-value cache and its bind to the top level.
`default_nettype none

module lkvc_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                in_valid,
    input wire                                in_ready,
    input wire                                command,
    input wire                                out_valid,
    input wire                                out_ready,
    input wire                                hit,
    input wire signed [lkvc_pkg::DATA_W-1:0]  read_value
);

    // A result word that is not taken holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value))
        else $error("result word changed while stalled");

    // A miss always reads as all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_value == lkvc_pkg::MISS_VALUE)
        else $error("miss without all-ones value");

    // Each word occupies the cache for its update cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted in the update cycle");

    // A get taken while the result register is empty is answered after its update state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == lkvc_pkg::CMD_GET) && !out_valid
        |=> ##1 out_valid)
        else $error("get produced no result");

    // A set never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == lkvc_pkg::CMD_SET) && !out_valid
        |=> ##1 !out_valid)
        else $error("set produced a result");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

`default_nettype wire

// ----- tb/sv/lkvc_tb_pkg.sv -----
// Scoreboard class that mirrors the LRU cache and checks its get results.
`timescale 1ns / 100ps

package lkvc_tb_pkg;

    import lkvc_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
    } reply_t;

    class lkvc_shadow;

        bit                live[SLOTS];
        logic [DATA_W-1:0] tag[SLOTS];
        logic [DATA_W-1:0] data[SLOTS];
        int unsigned       age[SLOTS];
        int unsigned       used;
        logic [CAP_W-1:0]  capacity;
        reply_t            replies[$];
        int unsigned       errors;
        int unsigned       gets;
        int unsigned       sets;
        int unsigned       hits;
        int unsigned       evictions;

        function new();
            foreach (live[i])
            begin
                live[i] = 1'b0;
                tag[i]  = '0;
                data[i] = '0;
                age[i]  = 0;
            end
            used      = 0;
            capacity  = CAP_RESET;
            errors    = 0;
            gets      = 0;
            sets      = 0;
            hits      = 0;
            evictions = 0;
        endfunction

        function void write_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t ns: MISMATCH %s", $time, msg);
        endfunction

        // Entries more recent than slot s age by one, then s becomes the newest.
        function void promote(int s);
            int unsigned r;
            r = age[s];
            foreach (live[i])
                if (live[i] && age[i] < r)
                    age[i]++;
            age[s] = 0;
        endfunction

        // Called for every word accepted on the input channel.
        function void accept_word(logic cmd, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
            int          s;
            int          oldest;
            int          slot;
            int unsigned cap_eff;
            reply_t      r;
            s = -1;
            foreach (live[i])
                if (s < 0 && live[i] && tag[i] == k)
                    s = i;
            if (cmd == CMD_GET)
            begin
                gets++;
                if (s >= 0)
                begin
                    hits++;
                    promote(s);
                    r.hit  = 1'b1;
                    r.data = data[s];
                end
                else
                begin
                    r.hit  = 1'b0;
                    r.data = MISS_VALUE;
                end
                replies.push_back(r);
                return;
            end
            sets++;
            if (s >= 0)
            begin
                data[s] = v;
                promote(s);
                return;
            end
            // Capacity zero acts as one, anything above the slot count saturates.
            cap_eff = capacity;
            if (cap_eff < 1)
                cap_eff = 1;
            if (cap_eff > SLOTS)
                cap_eff = SLOTS;
            if (used >= cap_eff)
            begin
                oldest = -1;
                foreach (live[i])
                    if (live[i] && (oldest < 0 || age[i] > age[oldest]))
                        oldest = i;
                if (oldest >= 0)
                begin
                    live[oldest] = 1'b0;
                    if (used > 0)
                        used--;
                    evictions++;
                end
            end
            slot = -1;
            foreach (live[i])
                if (slot < 0 && !live[i])
                    slot = i;
            if (slot < 0)
                return;
            foreach (live[i])
                if (live[i])
                    age[i]++;
            live[slot] = 1'b1;
            tag[slot]  = k;
            data[slot] = v;
            age[slot]  = 0;
            used++;
        endfunction

        // Called for every word accepted on the output channel.
        function void check_reply(logic h, logic [DATA_W-1:0] rv);
            reply_t want;
            if (replies.size() == 0)
            begin
                flag($sformatf("result with nothing outstanding: hit %b read_value %h", h, rv));
                return;
            end
            want = replies.pop_front();
            if (h !== want.hit)
                flag($sformatf("hit expected %b actual %b", want.hit, h));
            if (rv !== want.data)
                flag($sformatf("read_value expected %h actual %h", want.data, rv));
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench for the LRU key-value cache.
`timescale 1ns / 100ps

module tb_top;

    import lkvc_pkg::*;
    import lkvc_tb_pkg::*;

    localparam int unsigned LIMIT        = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CHOKE_CYCLES = 300;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     command;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;

    lkvc_shadow  cache_mirror;
    int unsigned cycle_count = 0;
    int unsigned caps_written = 0;
    bit          steady = 1'b0;
    bit          choke_req = 1'b0;

    lru_key_value_cache #(
        .MAX_ENTRIES (16)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Results are checked before the word of the same edge is noted; a result
    // can never belong to a word accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && out_ready)
                cache_mirror.check_reply(hit, read_value);
            if (in_valid && in_ready)
                cache_mirror.accept_word(command, key, value);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (choke_req)
            begin
                out_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_req = 1'b0;
            end
            else if (steady || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [DATA_W-1:0] k,
                             input logic [DATA_W-1:0] v);
        int unsigned gap;
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every get has returned and the last set has had time to land.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cache_mirror.replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cache_mirror.write_capacity(c);
        caps_written++;
    endtask

    // Random words over a small key pool so that hits, updates and evictions
    // are frequent; a tenth of the keys are fresh random patterns.
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned n_words,
                             input int unsigned quiet, input bit choke);
        logic [DATA_W-1:0] pool[$];
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;
        logic              cmd;
        int unsigned       pool_n;
        int unsigned       cap_eff;
        write_capacity(cap);
        cap_eff = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap;
        pool_n  = cap_eff + $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       pool.push_back(32'h8000_0000);
                1:       pool.push_back(32'h7FFF_FFFF);
                2:       pool.push_back(32'h0000_0000);
                3:       pool.push_back(32'hFFFF_FFFF);
                default: pool.push_back($urandom);
            endcase
        end
        if (choke)
            choke_req = 1'b1;
        for (int i = 0; i < n_words; i++)
        begin
            steady = (i < quiet);
            cmd = $urandom_range(0, 1) ? CMD_SET : CMD_GET;
            if ($urandom_range(0, 9) == 0)
                k = $urandom;
            else
                k = pool[$urandom_range(0, pool.size() - 1)];
            case ($urandom_range(0, 15))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'hFFFF_FFFF;
                3:       v = 32'h0000_0000;
                default: v = $urandom;
            endcase
            send_word(cmd, k, v);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        cache_mirror = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        command   <= CMD_GET;
        key       <= '0;
        value     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty cache, key and value extremes, a stored -1 that must still hit.
        send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678);
        send_word(CMD_GET, 32'h1234_5678, 32'h0000_0000);
        send_word(CMD_SET, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);

        // Capacity below the current count: each new key evicts exactly one.
        write_capacity(5'd2);
        send_word(CMD_SET, 32'h0000_0001, 32'h0000_0011);
        send_word(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_SET, 32'h0000_0002, 32'h0000_0022);
        send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);

        // Capacity zero behaves as one.
        write_capacity(5'd0);
        send_word(CMD_SET, 32'h0000_0003, 32'h0000_0033);
        send_word(CMD_SET, 32'h0000_0004, 32'h0000_0044);
        send_word(CMD_SET, 32'h0000_0005, 32'h0000_0055);
        send_word(CMD_GET, 32'h0000_0005, 32'h0000_0000);

        // Capacity above the slot count saturates.
        write_capacity(5'd31);
        send_word(CMD_SET, 32'h0000_0006, 32'h0000_0066);
        send_word(CMD_GET, 32'h0000_0003, 32'h0000_0000);
        send_word(CMD_GET, 32'h0000_0006, 32'h0000_0000);

        run_phase(5'd1, 75, 20, 1'b0);
        run_phase(5'd16, 80, 40, 1'b1);
        run_phase(5'd3, 75, 0, 1'b0);
        run_phase(5'd31, 75, 20, 1'b0);
        run_phase(5'd0, 70, 0, 1'b0);
        run_phase(5'd17, 75, 20, 1'b0);
        run_phase(5'd8, 75, 0, 1'b0);
        run_phase(5'd2, 70, 20, 1'b0);
        run_phase(5'($urandom_range(4, 15)), 80, 0, 1'b0);
        settle();

        $display("tb_top: %0d words (%0d gets, %0d sets), %0d hits, %0d evictions",
                 cache_mirror.gets + cache_mirror.sets, cache_mirror.gets,
                 cache_mirror.sets, cache_mirror.hits, cache_mirror.evictions);
        $display("tb_top: %0d capacity writes, %0d mismatches, %0d cycles",
                 caps_written, cache_mirror.errors, cycle_count);
        if (cache_mirror.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
